// ===== sv/nds_pkg.sv =====
// Package for the nearest-neighbor downscaler: widths, register and format codes,
// shared command and status structs. No dependencies.
`timescale 1ns / 1ps

package nds_pkg;

  localparam int DIM_W      = 13;          // frame dimensions and counters
  localparam int PROD_W     = 2 * DIM_W;   // accumulators and size products
  localparam int BND_W      = PROD_W + 1;  // selection window bounds
  localparam int PX_W       = 32;
  localparam int FMT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int OUT_MAX_W_DEF = 1280;
  localparam int OUT_MAX_H_DEF = 720;

  localparam logic [DIM_W-1:0] MIN_SIDE = DIM_W'(2);
  localparam logic [7:0]       ALPHA    = 8'hFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd2;

  // Source byte orders.
  localparam logic [FMT_W-1:0] FMT_BGRX = 3'd0;
  localparam logic [FMT_W-1:0] FMT_RGBX = 3'd1;
  localparam logic [FMT_W-1:0] FMT_XRGB = 3'd2;
  localparam logic [FMT_W-1:0] FMT_XBGR = 3'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic frame_clr;    // frame start accepted: zero counters, hold the pixel
    logic mul_load;     // register the cross products of the size test
    logic div_start;    // launch the size division
    logic size_direct;  // target size is the source size (or zero if too small)
    logic size_div;     // target size comes from the divider
    logic step_in;      // run one pixel from the input channel
    logic step_held;    // run the held frame-start pixel
  } nds_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic frame_small;
    logic over_max;
    logic div_done;
  } nds_sts_t;

endpackage

// ===== sv/nds_ifs.sv =====
// Channel interfaces of the downscaler: pixel input, pixel output and register writes.
// Depends on nds_pkg for the payload widths.
`timescale 1ns / 1ps

interface nds_in_if
  import nds_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [PX_W-1:0]     pixel_word;
  logic                frame_start;

  modport source (output valid, pixel_word, frame_start, input ready);
  modport sink   (input valid, pixel_word, frame_start, output ready);
endinterface

interface nds_out_if
  import nds_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [PX_W-1:0]     pixel_bgra;
  logic                last_in_frame;

  modport source (output valid, pixel_bgra, last_in_frame, input ready);
  modport sink   (input valid, pixel_bgra, last_in_frame, output ready);
endinterface

interface nds_cfg_if
  import nds_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/nds_div.sv =====
// Restoring divider, one quotient bit per cycle, used to size a frame.
// Depends on nds_pkg for the operand widths.
`timescale 1ns / 1ps

module nds_div
  import nds_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [DIM_W-1:0]  divisor,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIM_W-1:0]  rem_r, rem_nxt;
  logic [DIM_W-1:0]  dvs_r, dvs_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [DIM_W:0]    trial;
  logic              fits;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[PROD_W-1]};
    fits     = trial >= {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(PROD_W);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? DIM_W'(trial - {1'b0, dvs_r}) : trial[DIM_W-1:0];
      quo_nxt = {quo_r[PROD_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider reports done while still busy");
  a_fall_done: assert property (@(posedge clk) disable iff (!rst_n) $fell(busy_r) |-> done_r)
    else $error("divider stopped without reporting done");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider started while a division is running");

endmodule

// ===== sv/nds_datapath.sv =====
// Datapath of the downscaler: registers, frame counters, selection windows,
// sizing products, the size divider and the output register.
// Depends on nds_pkg and nds_div.
`timescale 1ns / 1ps

module nds_datapath
  import nds_pkg::*;
#(
  parameter int unsigned OUT_MAX_W = OUT_MAX_W_DEF,
  parameter int unsigned OUT_MAX_H = OUT_MAX_H_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nds_cmd_t              cmd,
  output nds_sts_t              sts,
  input  logic [PX_W-1:0]       in_pixel_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [PX_W-1:0]       out_pixel_bgra,
  output logic                  out_last_in_frame
);

  localparam logic [DIM_W-1:0] MAX_W = DIM_W'(OUT_MAX_W);
  localparam logic [DIM_W-1:0] MAX_H = DIM_W'(OUT_MAX_H);
  localparam int               PAD_W = PROD_W - DIM_W;

  // Configuration registers.
  logic [DIM_W-1:0] src_w_r, src_w_nxt;
  logic [DIM_W-1:0] src_h_r, src_h_nxt;
  logic [FMT_W-1:0] fmt_r, fmt_nxt;

  // Frame state.
  logic [DIM_W-1:0]  scol_r, scol_nxt;
  logic [DIM_W-1:0]  srow_r, srow_nxt;
  logic [DIM_W-1:0]  tcol_r, tcol_nxt;
  logic [DIM_W-1:0]  trow_r, trow_nxt;
  logic [DIM_W-1:0]  tw_r, tw_nxt;
  logic [DIM_W-1:0]  th_r, th_nxt;
  logic [PROD_W-1:0] cacc_r, cacc_nxt;
  logic [PROD_W-1:0] racc_r, racc_nxt;
  // Window [lo, hi) = [s*(t-1), (s+1)*(t-1)) replaces the floor division test.
  logic [BND_W-1:0]  col_lo_r, col_lo_nxt;
  logic [BND_W-1:0]  col_hi_r, col_hi_nxt;
  logic [BND_W-1:0]  row_lo_r, row_lo_nxt;
  logic [BND_W-1:0]  row_hi_r, row_hi_nxt;

  // Sizing.
  logic [PX_W-1:0]   held_px_r, held_px_nxt;
  logic [PROD_W-1:0] prod_wh_r, prod_wh_nxt;
  logic [PROD_W-1:0] prod_hw_r, prod_hw_nxt;
  logic              wfirst;
  logic [PROD_W-1:0] quotient;
  logic [DIM_W-1:0]  q_side;
  logic              div_done;
  logic              size_we;
  logic [DIM_W-1:0]  tw_new, th_new;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [PX_W-1:0]   out_px_r, out_px_nxt;
  logic              out_last_r, out_last_nxt;

  // Step terms.
  logic              step;
  logic [PX_W-1:0]   px;
  logic [DIM_W-1:0]  dw, dh;
  logic              gate, row_hit, col_hit, emit, row_end;
  logic [BND_W-1:0]  cacc_x, racc_x;

  function automatic logic [PX_W-1:0] to_bgra(input logic [PX_W-1:0]  p,
                                              input logic [FMT_W-1:0] f);
    logic [7:0] b, g, r;
    begin
      unique case (f)
        FMT_RGBX: begin b = p[23:16]; g = p[15:8];  r = p[7:0];   end
        FMT_XRGB: begin b = p[31:24]; g = p[23:16]; r = p[15:8];  end
        FMT_XBGR: begin b = p[15:8];  g = p[23:16]; r = p[31:24]; end
        default:  begin b = p[7:0];   g = p[15:8];  r = p[23:16]; end
      endcase
      to_bgra = {ALPHA, r, g, b};
    end
  endfunction

  nds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (wfirst ? prod_wh_r : prod_hw_r),
    .divisor  (wfirst ? src_w_r : src_h_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    // Both sides scale by the width ratio when MAX_W/w is the smaller one or the two ratios tie.
    wfirst = prod_wh_r <= prod_hw_r;
    q_side = (quotient < PROD_W'(MIN_SIDE)) ? MIN_SIDE : quotient[DIM_W-1:0];

    step   = cmd.step_in | cmd.step_held;
    px     = cmd.step_held ? held_px_r : in_pixel_word;
    dw     = tw_r - DIM_W'(1);
    dh     = th_r - DIM_W'(1);
    cacc_x = {1'b0, cacc_r};
    racc_x = {1'b0, racc_r};
    gate   = (tw_r >= MIN_SIDE) && (th_r >= MIN_SIDE) &&
             (trow_r < th_r) && (srow_r < src_h_r);
    row_hit = (row_lo_r <= racc_x) && (racc_x < row_hi_r);
    col_hit = (tcol_r < tw_r) && (col_lo_r <= cacc_x) && (cacc_x < col_hi_r);
    emit    = step && gate && row_hit && col_hit;
    row_end = ({1'b0, scol_r} + (DIM_W + 1)'(1)) >= {1'b0, src_w_r};

    src_w_nxt   = src_w_r;
    src_h_nxt   = src_h_r;
    fmt_nxt     = fmt_r;
    scol_nxt    = scol_r;
    srow_nxt    = srow_r;
    tcol_nxt    = tcol_r;
    trow_nxt    = trow_r;
    tw_nxt      = tw_r;
    th_nxt      = th_r;
    cacc_nxt    = cacc_r;
    racc_nxt    = racc_r;
    col_lo_nxt  = col_lo_r;
    col_hi_nxt  = col_hi_r;
    row_lo_nxt  = row_lo_r;
    row_hi_nxt  = row_hi_r;
    held_px_nxt = held_px_r;
    prod_wh_nxt = prod_wh_r;
    prod_hw_nxt = prod_hw_r;
    out_px_nxt  = out_px_r;
    out_last_nxt = out_last_r;
    out_valid_nxt = out_valid_r & ~out_ready;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:    src_w_nxt = cfg_data[DIM_W-1:0];
        REG_SRC_HEIGHT:   src_h_nxt = cfg_data[DIM_W-1:0];
        REG_PIXEL_FORMAT: fmt_nxt   = cfg_data[FMT_W-1:0];
        default: ;
      endcase
    end

    if (cmd.frame_clr) begin
      scol_nxt    = '0;
      srow_nxt    = '0;
      tcol_nxt    = '0;
      trow_nxt    = '0;
      cacc_nxt    = '0;
      racc_nxt    = '0;
      col_lo_nxt  = '0;
      row_lo_nxt  = '0;
      held_px_nxt = in_pixel_word;
    end

    if (cmd.mul_load) begin
      prod_wh_nxt = {{PAD_W{1'b0}}, MAX_W} * {{PAD_W{1'b0}}, src_h_r};
      prod_hw_nxt = {{PAD_W{1'b0}}, MAX_H} * {{PAD_W{1'b0}}, src_w_r};
    end

    size_we = cmd.size_direct | cmd.size_div;
    if (cmd.size_div) begin
      tw_new = wfirst ? MAX_W : q_side;
      th_new = wfirst ? q_side : MAX_H;
    end else if (sts.frame_small) begin
      tw_new = '0;
      th_new = '0;
    end else begin
      tw_new = src_w_r;
      th_new = src_h_r;
    end
    if (size_we) begin
      tw_nxt     = tw_new;
      th_nxt     = th_new;
      col_hi_nxt = BND_W'(tw_new - DIM_W'(1));
      row_hi_nxt = BND_W'(th_new - DIM_W'(1));
    end

    if (step && gate) begin
      if (emit) begin
        out_valid_nxt = 1'b1;
        out_px_nxt    = to_bgra(px, fmt_r);
        out_last_nxt  = (trow_r == dh) && (tcol_r == dw);
        tcol_nxt      = tcol_r + DIM_W'(1);
        cacc_nxt      = cacc_r + PROD_W'(src_w_r - DIM_W'(1));
      end
      if (row_end) begin
        scol_nxt   = '0;
        srow_nxt   = srow_r + DIM_W'(1);
        row_lo_nxt = row_lo_r + BND_W'(dh);
        row_hi_nxt = row_hi_r + BND_W'(dh);
        if (row_hit) begin
          trow_nxt = trow_r + DIM_W'(1);
          racc_nxt = racc_r + PROD_W'(src_h_r - DIM_W'(1));
        end
        tcol_nxt   = '0;
        cacc_nxt   = '0;
        col_lo_nxt = '0;
        col_hi_nxt = BND_W'(dw);
      end else begin
        scol_nxt   = scol_r + DIM_W'(1);
        col_lo_nxt = col_lo_r + BND_W'(dw);
        col_hi_nxt = col_hi_r + BND_W'(dw);
      end
    end
  end

  always_comb begin
    sts.out_free    = ~out_valid_r | out_ready;
    sts.frame_small = (src_w_r < MIN_SIDE) || (src_h_r < MIN_SIDE);
    sts.over_max    = (src_w_r > MAX_W) || (src_h_r > MAX_H);
    sts.div_done    = div_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r     <= '0;
      src_h_r     <= '0;
      fmt_r       <= '0;
      scol_r      <= '0;
      srow_r      <= '0;
      tcol_r      <= '0;
      trow_r      <= '0;
      tw_r        <= '0;
      th_r        <= '0;
      cacc_r      <= '0;
      racc_r      <= '0;
      col_lo_r    <= '0;
      col_hi_r    <= '0;
      row_lo_r    <= '0;
      row_hi_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      src_w_r     <= src_w_nxt;
      src_h_r     <= src_h_nxt;
      fmt_r       <= fmt_nxt;
      scol_r      <= scol_nxt;
      srow_r      <= srow_nxt;
      tcol_r      <= tcol_nxt;
      trow_r      <= trow_nxt;
      tw_r        <= tw_nxt;
      th_r        <= th_nxt;
      cacc_r      <= cacc_nxt;
      racc_r      <= racc_nxt;
      col_lo_r    <= col_lo_nxt;
      col_hi_r    <= col_hi_nxt;
      row_lo_r    <= row_lo_nxt;
      row_hi_r    <= row_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
    held_px_r  <= held_px_nxt;
    prod_wh_r  <= prod_wh_nxt;
    prod_hw_r  <= prod_hw_nxt;
    out_px_r   <= out_px_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_bgra    = out_px_r;
  assign out_last_in_frame = out_last_r;

  a_size_floor: assert property (@(posedge clk) disable iff (!rst_n)
      (tw_r == '0) || (tw_r >= MIN_SIDE))
    else $error("target width is one but not zero");
  a_size_pair: assert property (@(posedge clk) disable iff (!rst_n)
      (tw_r == '0) == (th_r == '0))
    else $error("only one side of the target size is zero");
  a_tgt_bound: assert property (@(posedge clk) disable iff (!rst_n)
      (tcol_r <= tw_r) && (trow_r <= th_r))
    else $error("target position ran past the target size");

endmodule

// ===== sv/nds_ctrl.sv =====
// Controller of the downscaler: input handshake, frame sizing sequence and
// pixel steps. Depends on nds_pkg for the command and status structs.
`timescale 1ns / 1ps

module nds_ctrl
  import nds_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_frame_start,
  output logic     in_ready,
  input  nds_sts_t sts,
  output nds_cmd_t cmd
);

  localparam logic [2:0] ST_RUN  = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_PICK = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_HELD = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if (in_frame_start) begin
            cmd.frame_clr = 1'b1;
            state_nxt     = ST_MUL;
          end else begin
            cmd.step_in = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = ST_PICK;
      end
      ST_PICK: begin
        if (sts.frame_small || !sts.over_max) begin
          cmd.size_direct = 1'b1;
          state_nxt       = ST_HELD;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.size_div = 1'b1;
          state_nxt    = ST_HELD;
        end
      end
      ST_HELD: begin
        if (sts.out_free) begin
          cmd.step_held = 1'b1;
          state_nxt     = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_clr_mul: assert property (@(posedge clk) disable iff (!rst_n) cmd.frame_clr |=> cmd.mul_load)
    else $error("frame start not followed by the size products");
  a_held_path: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == ST_HELD) |->
      ($past(state_r) == ST_PICK || $past(state_r) == ST_DIV || $past(state_r) == ST_HELD))
    else $error("held pixel stage entered without sizing");
  a_size_once: assert property (@(posedge clk) disable iff (!rst_n)
      (cmd.size_direct || cmd.size_div) |=> (state_r == ST_HELD))
    else $error("size written outside the sizing sequence");

endmodule

// ===== sv/nearest_downscale_swizzle.sv =====
// Top level of the nearest-neighbor downscaler with BGRA reordering.
// Depends on nds_pkg, nds_ifs, nds_ctrl, nds_datapath and nds_div.
`timescale 1ns / 1ps

// This block takes source pixels in raster order and passes on the nearest-neighbor
// subset that forms a frame of at most OUT_MAX_W by OUT_MAX_H, each one reordered to
// bytes B, G, R, 255 from bit 0 upward, with last_in_frame set on the final pixel.
// The pixel that carries frame_start restarts the frame: the output size is then
// worked out from src_width and src_height, and a frame larger than the maximum is
// scaled on both sides by the smaller ratio as an exact integer floor with a minimum
// of two. Ordinary pixels stream at one pixel per clock whenever the output side
// keeps up; the input is held off while a result sits in the output register and
// the receiver does not take it, and while a frame-start pixel is being sized, and a
// new pixel is accepted in the same cycle as the waiting result leaves. A frame-start
// pixel passes through loading the size products, picking the sizing path and
// running the held pixel; when scaling is needed, the 26-step serial divider
// computes the scaled side and reports done before the held pixel runs. Frames with a
// side below two give no output until the next frame start, as do pixels seen before
// the first frame start. Registers are written over the cfg channel, which is always
// ready; they should only change while no transaction is in flight, otherwise the
// geometry of the running frame is not meaningful.
module nearest_downscale_swizzle
  import nds_pkg::*;
#(
  parameter int unsigned OUT_MAX_W = OUT_MAX_W_DEF,
  parameter int unsigned OUT_MAX_H = OUT_MAX_H_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  nds_in_if.sink     in_chan,
  nds_out_if.source  out_chan,
  nds_cfg_if.sink    cfg_chan
);

  nds_cmd_t cmd;
  nds_sts_t sts;
  logic     in_ready;

  // Register writes are never stalled: the cfg channel is always ready.
  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = in_ready;

  // The controller owns the input handshake and sequences frame sizing.
  nds_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_chan.valid),
    .in_frame_start (in_chan.frame_start),
    .in_ready       (in_ready),
    .sts            (sts),
    .cmd            (cmd)
  );

  // The datapath holds the registers, frame counters and the output register.
  nds_datapath #(
    .OUT_MAX_W (OUT_MAX_W),
    .OUT_MAX_H (OUT_MAX_H)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_pixel_word     (in_chan.pixel_word),
    .cfg_we            (cfg_chan.valid),
    .cfg_index         (cfg_chan.index),
    .cfg_data          (cfg_chan.data),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_pixel_bgra    (out_chan.pixel_bgra),
    .out_last_in_frame (out_chan.last_in_frame)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for nearest_downscale_swizzle: directed frames, random traffic
// with idling and stalls on both sides, and a predictor that scores every output pixel.
// Depends on nds_pkg, the channel interfaces in nds_ifs and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
  import nds_pkg::*;

  localparam int unsigned OUT_W_MAX   = OUT_MAX_W_DEF;
  localparam int unsigned OUT_H_MAX   = OUT_MAX_H_DEF;
  localparam int unsigned DIM_MAX     = (1 << DIM_W) - 1;
  // Index 3 maps to no register; a write there must leave the block untouched.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // Quiet cycles after the last result that leave the block idle, also when a frame-start
  // pixel still needs the divider.
  localparam int unsigned SETTLE      = 64;
  localparam int unsigned DRAIN_LIMIT = 20000;
  // Frames with more pixels than this are only sent in part by the random traffic.
  localparam int unsigned LARGE_FRAME = 160;
  // Timeout for the whole run, far above the longest correct run.
  localparam longint unsigned TIMEOUT_NS = 64'd20_000_000;

  typedef struct packed {
    logic [PX_W-1:0] pixel_bgra;
    logic            last_in_frame;
  } out_pixel_t;

  logic clk;
  logic rst_n;

  nds_in_if  in_if ();
  nds_out_if out_if ();
  nds_cfg_if cfg_if ();

  nearest_downscale_swizzle #(
    .OUT_MAX_W(OUT_W_MAX),
    .OUT_MAX_H(OUT_H_MAX)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  // Shadow copy of the registers and the frame state of the block.
  logic [DIM_W-1:0]  cfg_width, cfg_height;
  logic [FMT_W-1:0]  cfg_format;
  logic [DIM_W-1:0]  src_col, src_row, tgt_col, tgt_row, tgt_w, tgt_h;
  logic [PROD_W-1:0] col_acc, row_acc;

  // Output pixels that the block still owes, oldest first.
  out_pixel_t expected_pixels[$];

  int unsigned mismatches    = 0;
  int unsigned pixels_sent   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------

  // Output size for a new frame. A side below two disables the frame. Oversized frames
  // shrink both sides by the tighter of the two ratios, compared by cross products so
  // that the floors stay exact, and neither side drops below two.
  function automatic void size_target();
    longint unsigned w, h, tw, th;
    w  = cfg_width;
    h  = cfg_height;
    tw = w;
    th = h;
    if (w < MIN_SIDE || h < MIN_SIDE) begin
      tgt_w = '0;
      tgt_h = '0;
      return;
    end
    if (w > OUT_W_MAX || h > OUT_H_MAX) begin
      if (64'(OUT_W_MAX) * h <= 64'(OUT_H_MAX) * w) begin
        tw = OUT_W_MAX;
        th = (h * OUT_W_MAX) / w;
      end else begin
        th = OUT_H_MAX;
        tw = (w * OUT_H_MAX) / h;
      end
      if (tw < MIN_SIDE) tw = MIN_SIDE;
      if (th < MIN_SIDE) th = MIN_SIDE;
    end
    tgt_w = tw[DIM_W-1:0];
    tgt_h = th[DIM_W-1:0];
  endfunction

  // Reorders a source pixel to B, G, R, alpha. Codes above the last known format
  // fall back to the B, G, R, x order.
  function automatic logic [PX_W-1:0] swizzle_bgra(input logic [PX_W-1:0] px);
    logic [7:0] b, g, r;
    case (cfg_format)
      FMT_RGBX: begin
        b = px[23:16]; g = px[15:8];  r = px[7:0];
      end
      FMT_XRGB: begin
        b = px[31:24]; g = px[23:16]; r = px[15:8];
      end
      FMT_XBGR: begin
        b = px[15:8];  g = px[23:16]; r = px[31:24];
      end
      default: begin
        b = px[7:0];   g = px[15:8];  r = px[23:16];
      end
    endcase
    return {ALPHA, r, g, b};
  endfunction

  // Advances the shadow state by one accepted source pixel and queues the output pixel
  // it selects, if any. The register values are used as they stand, so a resize in
  // the middle of a frame is followed exactly, wrapping included.
  function automatic void step_frame(input logic [PX_W-1:0] px, input logic fs);
    bit         row_hit;
    out_pixel_t item;
    if (fs) begin
      src_col = '0;
      src_row = '0;
      tgt_col = '0;
      tgt_row = '0;
      col_acc = '0;
      row_acc = '0;
      size_target();
    end
    // No active frame, or the frame is already complete.
    if (tgt_w < MIN_SIDE || tgt_h < MIN_SIDE || tgt_row >= tgt_h || src_row >= cfg_height)
      return;
    row_hit = (32'(row_acc) / 32'(tgt_h - 13'd1)) == 32'(src_row);
    if (row_hit && tgt_col < tgt_w &&
        (32'(col_acc) / 32'(tgt_w - 13'd1)) == 32'(src_col)) begin
      item.pixel_bgra    = swizzle_bgra(px);
      item.last_in_frame = (tgt_row == tgt_h - 13'd1) && (tgt_col == tgt_w - 13'd1);
      expected_pixels.push_back(item);
      tgt_col = tgt_col + 13'd1;
      col_acc = col_acc + PROD_W'(cfg_width - 13'd1);
    end
    // End of a source row: the target row only moves on when this row was selected.
    if (32'(src_col) + 32'd1 >= 32'(cfg_width)) begin
      src_col = '0;
      src_row = src_row + 13'd1;
      if (row_hit) begin
        tgt_row = tgt_row + 13'd1;
        row_acc = row_acc + PROD_W'(cfg_height - 13'd1);
      end
      tgt_col = '0;
      col_acc = '0;
    end else begin
      src_col = src_col + 13'd1;
    end
  endfunction

  // ---------------------------------------------------------------------------------
  // Output side: ready pattern and checking
  // ---------------------------------------------------------------------------------

  // A long hold-off requested by a test overrides the random ready pattern.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_pixel_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        $error("output pixel %h (last %0b) with no pixel expected",
               out_if.pixel_bgra, out_if.last_in_frame);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_if.pixel_bgra !== want.pixel_bgra) begin
          $error("pixel_bgra: expected %h, actual %h", want.pixel_bgra, out_if.pixel_bgra);
          mismatches++;
        end
        if (out_if.last_in_frame !== want.last_in_frame) begin
          $error("last_in_frame: expected %0b, actual %0b",
                 want.last_in_frame, out_if.last_in_frame);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Input side and register writes
  // ---------------------------------------------------------------------------------

  // Offers one source pixel and returns on the falling edge after the transaction,
  // with valid still high so that the next pixel can follow without a gap.
  task automatic send_pixel(input logic [PX_W-1:0] px, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.pixel_word  <= px;
    in_if.frame_start <= fs;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    step_frame(px, fs);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Stops offering pixels and waits for every expected pixel, then lets the block
  // settle for the given number of cycles.
  task automatic drain_pixels(input int unsigned settle);
    int unsigned waited;
    waited = 0;
    in_if.valid <= 1'b0;
    while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_pixels.size() != 0) begin
      $error("%0d expected pixels never came out", expected_pixels.size());
      mismatches++;
      expected_pixels.delete();
    end
    @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // The bits above each field carry random values; the block must ignore them.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom());
    case (idx)
      REG_SRC_WIDTH, REG_SRC_HEIGHT: word[DIM_W-1:0] = value[DIM_W-1:0];
      REG_PIXEL_FORMAT:              word[FMT_W-1:0] = value[FMT_W-1:0];
      default:                       word = CFG_DATA_W'(value);
    endcase
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= word;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    case (idx)
      REG_SRC_WIDTH:    cfg_width  = word[DIM_W-1:0];
      REG_SRC_HEIGHT:   cfg_height = word[DIM_W-1:0];
      REG_PIXEL_FORMAT: cfg_format = word[FMT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Only called with the block idle, right after drain_pixels.
  task automatic configure(input int unsigned width, input int unsigned height,
                           input int unsigned fmt);
    write_reg(REG_SRC_WIDTH, width);
    write_reg(REG_SRC_HEIGHT, height);
    write_reg(REG_PIXEL_FORMAT, fmt);
    if ($urandom_range(5) == 0) write_reg(REG_UNUSED, $urandom());
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------

  // Pixels seen before any frame start must be dropped.
  task automatic test_before_first_frame();
    drain_pixels(SETTLE);
    configure(3, 2, FMT_BGRX);
    send_pixel($urandom(), 1'b0);
    send_pixel($urandom(), 1'b0);
  endtask

  // Every format code, the unknown ones included, on a 2x2 frame whose first pixel
  // is always selected; then the all-zero and all-one pixel words.
  task automatic test_pixel_formats();
    for (int fmt = 0; fmt < (1 << FMT_W); fmt++) begin
      drain_pixels(SETTLE);
      configure(2, 2, fmt);
      send_pixel(32'hD4C3_B2A1, 1'b1);
    end
    drain_pixels(SETTLE);
    configure(2, 2, FMT_BGRX);
    send_pixel('0, 1'b1);
    send_pixel('1, 1'b1);
  endtask

  // A side below two, zero included, gives a frame with no output at all.
  task automatic test_small_frames();
    drain_pixels(SETTLE);
    configure(1, 6, FMT_XRGB);
    send_pixel($urandom(), 1'b1);
    send_pixel($urandom(), 1'b0);
    drain_pixels(SETTLE);
    configure(5, 0, FMT_XBGR);
    send_pixel($urandom(), 1'b1);
    send_pixel($urandom(), 1'b0);
  endtask

  // A full frame with a surplus pixel after it, a frame cut short by an early frame
  // start, and the full frame that replaces it.
  task automatic test_excess_and_restart();
    drain_pixels(SETTLE);
    configure(2, 2, FMT_RGBX);
    for (int i = 0; i < 5; i++) send_pixel($urandom(), i == 0);
    send_pixel($urandom(), 1'b1);
    send_pixel($urandom(), 1'b0);
    for (int i = 0; i < 4; i++) send_pixel($urandom(), i == 0);
  endtask

  // One random frame. Most are small and complete; some get surplus pixels, are cut
  // short, carry stray frame starts, or are resized while they run. A few sit near the
  // scaling limits or at the extremes of the size registers and are sent only in part.
  task automatic random_frame();
    int unsigned w, h, shape, kind, npix, full, extra;
    shape = $urandom_range(99);
    if (shape < 78) begin
      w = $urandom_range(12, 2);
      h = $urandom_range(8, 2);
    end else if (shape < 86) begin
      if ($urandom_range(1)) begin
        w = $urandom_range(1);
        h = $urandom_range(10);
      end else begin
        w = $urandom_range(10);
        h = $urandom_range(1);
      end
    end else if (shape < 94) begin
      if ($urandom_range(1)) begin
        w = $urandom_range(OUT_W_MAX + 10, OUT_W_MAX - 10);
        h = $urandom_range(3, 2);
      end else begin
        w = $urandom_range(3, 2);
        h = $urandom_range(OUT_H_MAX + 10, OUT_H_MAX - 10);
      end
    end else begin
      w = $urandom_range(1) ? DIM_MAX : $urandom_range(DIM_MAX);
      h = $urandom_range(1) ? DIM_MAX : $urandom_range(DIM_MAX);
    end

    // Often the new frame follows the last one directly, sizes unchanged.
    if ($urandom_range(99) < 40) begin
      w = cfg_width;
      h = cfg_height;
    end else begin
      drain_pixels(SETTLE);
      configure(w, h, $urandom_range((1 << FMT_W) - 1));
    end

    full = w * h;
    kind = $urandom_range(99);
    if (full > LARGE_FRAME) npix = $urandom_range(60, 1);
    else if (kind < 70)     npix = full;
    else if (kind < 82)     npix = full + $urandom_range(6, 1);
    else                    npix = $urandom_range(full, 1);
    if (npix == 0) npix = $urandom_range(4, 1);

    for (int i = 0; i < npix; i++)
      send_pixel($urandom(), (i == 0) || (kind >= 94 && $urandom_range(5) == 0));

    // Resize while the frame is still open: later pixels follow the new registers.
    if (kind >= 88 && kind < 94 && full <= LARGE_FRAME) begin
      drain_pixels(SETTLE);
      configure($urandom_range(12), $urandom_range(8), $urandom_range((1 << FMT_W) - 1));
      extra = $urandom_range(12, 1);
      for (int i = 0; i < extra; i++) send_pixel($urandom(), 1'b0);
    end
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int unsigned start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = pixels_sent;
    while (pixels_sent - start < count) random_frame();
  endtask

  // Downscaled frames that drop source lines: the first rows of a tall frame that
  // keeps about every other row, and the start of the first row of a wide frame that
  // keeps about every other column.
  task automatic test_downscale();
    drain_pixels(SETTLE);
    configure(2, 2 * OUT_H_MAX + 1, $urandom_range((1 << FMT_W) - 1));
    for (int i = 0; i < 80; i++) send_pixel($urandom(), i == 0);
    drain_pixels(SETTLE);
    configure(2 * OUT_W_MAX + 1, 2, $urandom_range((1 << FMT_W) - 1));
    for (int i = 0; i < 80; i++) send_pixel($urandom(), i == 0);
  endtask

  // The receiver holds off for a long stretch while an 8x8 frame streams in, so the
  // block fills and stalls its input. Halfway through, the sender waits for every
  // expected pixel before going on with the same frame.
  task automatic test_backpressure();
    drain_pixels(SETTLE);
    configure(8, 8, $urandom_range((1 << FMT_W) - 1));
    hold_request = 300;
    for (int i = 0; i < 32; i++) send_pixel($urandom(), i == 0);
    drain_pixels(0);
    for (int i = 0; i < 32; i++) send_pixel($urandom(), 1'b0);
  endtask

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.pixel_word  = '0;
    in_if.frame_start = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_SRC_WIDTH;
    cfg_if.data       = '0;
    out_if.ready      = 1'b0;
    cfg_width  = '0;
    cfg_height = '0;
    cfg_format = FMT_BGRX;
    src_col = '0;
    src_row = '0;
    tgt_col = '0;
    tgt_row = '0;
    tgt_w   = '0;
    tgt_h   = '0;
    col_acc = '0;
    row_acc = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 83;
    test_before_first_frame();
    test_pixel_formats();
    test_small_frames();
    test_excess_and_restart();

    test_random_traffic(490, 13, 83);
    test_random_traffic(490, 83, 13);
    test_random_traffic(470, 0, 0);

    test_downscale();
    test_backpressure();

    drain_pixels(SETTLE);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
